// File: sv/lmts_pkg.sv
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared constants for the display mode timing and status interrupt block:
// mode lengths, frame geometry, command codes and mode codes.
// ----------------------------------------------------------------------------
package lmts_pkg;

   // Cycle counts per mode and line geometry.
   localparam logic [9:0] SEARCH_CYCLES   = 10'd80;
   localparam logic [9:0] TRANSFER_CYCLES = 10'd172;
   localparam logic [9:0] HBLANK_CYCLES   = 10'd204;
   localparam logic [9:0] LINE_CYCLES     = 10'd456;
   localparam logic [7:0] VISIBLE_LINES   = 8'd144;
   localparam logic [8:0] TOTAL_LINES     = 9'd154;
   localparam logic [9:0] COUNT_MAX       = 10'd1023;

   // Register reset values.
   localparam logic [7:0] CONTROL_RESET   = 8'h91;

   // Command codes carried on the request tuser.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_WR_CONTROL  = 3'd1;
   localparam logic [2:0] CMD_WR_ENABLES  = 3'd2;
   localparam logic [2:0] CMD_WR_COMPARE  = 3'd3;
   localparam logic [2:0] CMD_RECHECK     = 3'd4;

   // Scan modes.
   localparam logic [1:0] MODE_HBLANK     = 2'd0;
   localparam logic [1:0] MODE_VBLANK     = 2'd1;
   localparam logic [1:0] MODE_SEARCH     = 2'd2;
   localparam logic [1:0] MODE_TRANSFER   = 2'd3;

   // Bit positions.
   localparam int DISPLAY_ON_BIT = 7;
   localparam int EN_HBLANK_BIT  = 0;
   localparam int EN_VBLANK_BIT  = 1;
   localparam int EN_SEARCH_BIT  = 2;
   localparam int EN_COMPARE_BIT = 3;

endpackage

// File: sv/lcd_mode_timing_stat_irq.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_stat_irq
// Scan mode sequencer of a line-based display with vblank and status
// interrupt pulses and status readback, one word in and one word out per item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+--------------
//  req_     | in  | tick_cycles[6:0], write_data[14:7], pad    | command[2:0]
//  rsp_     | out | status_read[7:0], line_number[15:8],       | -
//           |     | mode_now[17:16], stat_irq[18],             |
//           |     | vblank_irq[19], render_line[20], pad       |
//
// Each request word is handled in the cycle it is accepted: the state
// registers and the result register load on the same edge, so one word per
// cycle passes while rsp_tready holds; the result is out in the next cycle.
// The single result register sets the rate: a new word is taken whenever that
// register is empty or is being drained in the same cycle.
// A stalled rsp_tready holds the result and drops req_tready until it drains.
// reset (synchronous, active high) restores the register defaults: control
// 0x91, search mode, line and cycle count zero, no result pending.
// ----------------------------------------------------------------------------
module lcd_mode_timing_stat_irq
   import lmts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tick_cycles[6:0], write_data[14:7], zero[15]
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status_read, line_number, mode_now, stat_irq,
                                    // vblank_irq, render_line, zero[23:21]
);

   // Architectural state.
   logic [7:0] control_ff, control_in;
   logic [3:0] enables_ff, enables_in;
   logic [7:0] compare_ff, compare_in;
   logic [7:0] line_ff, line_in;
   logic [1:0] mode_ff, mode_in;
   logic [9:0] count_ff, count_in;
   logic       prev_irq_ff, prev_irq_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff, out_data_in;

   logic        req_fire;
   logic [2:0]  command;
   logic [6:0]  tick_cycles;
   logic [7:0]  write_data;
   logic [10:0] count_sum;
   logic [9:0]  count_sat;
   logic [8:0]  next_line;
   logic        evaluate;
   logic        level;
   logic        stat_pulse;
   logic        vblank_pulse;
   logic        render;
   logic [7:0]  status_read;

   assign command     = req_tuser;
   assign tick_cycles = req_tdata[6:0];
   assign write_data  = req_tdata[14:7];

   // Take a new word while the result register is empty or draining.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign count_sum = {1'b0, count_ff} + {4'd0, tick_cycles};
   assign count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[9:0];
   assign next_line = {1'b0, line_ff} + 9'd1;

   always_comb begin
      control_in   = control_ff;
      enables_in   = enables_ff;
      compare_in   = compare_ff;
      line_in      = line_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      evaluate     = 1'b0;
      vblank_pulse = 1'b0;
      render       = 1'b0;
      case (command)
         CMD_TICK: begin
            if (control_ff[DISPLAY_ON_BIT]) begin
               count_in = count_sat;
               // At most one mode change; subtract the finished mode's length.
               case (mode_ff)
                  MODE_SEARCH: begin
                     if (count_sat >= SEARCH_CYCLES) begin
                        count_in = count_sat - SEARCH_CYCLES;
                        mode_in  = MODE_TRANSFER;
                     end
                  end
                  MODE_TRANSFER: begin
                     if (count_sat >= TRANSFER_CYCLES) begin
                        count_in = count_sat - TRANSFER_CYCLES;
                        render   = (line_ff < VISIBLE_LINES);
                        mode_in  = MODE_HBLANK;
                        evaluate = 1'b1;
                     end
                  end
                  MODE_HBLANK: begin
                     if (count_sat >= HBLANK_CYCLES) begin
                        count_in = count_sat - HBLANK_CYCLES;
                        line_in  = next_line[7:0];   // wraps modulo 256
                        if (next_line[7:0] == VISIBLE_LINES) begin
                           mode_in      = MODE_VBLANK;
                           vblank_pulse = 1'b1;
                        end else begin
                           mode_in = MODE_SEARCH;
                        end
                        evaluate = 1'b1;
                     end
                  end
                  default: begin
                     // vblank: whole lines, wrap to line 0 at end of frame
                     if (count_sat >= LINE_CYCLES) begin
                        count_in = count_sat - LINE_CYCLES;
                        if (next_line >= TOTAL_LINES) begin
                           line_in = 8'd0;
                           mode_in = MODE_SEARCH;
                        end else begin
                           line_in = next_line[7:0];
                        end
                        evaluate = 1'b1;
                     end
                  end
               endcase
            end
         end
         CMD_WR_CONTROL: begin
            control_in = write_data;
            if (control_ff[DISPLAY_ON_BIT] && !write_data[DISPLAY_ON_BIT]) begin
               line_in  = 8'd0;
               mode_in  = MODE_HBLANK;
               count_in = 10'd0;
            end else if (!control_ff[DISPLAY_ON_BIT] && write_data[DISPLAY_ON_BIT]) begin
               mode_in  = MODE_SEARCH;
               count_in = 10'd0;
               evaluate = 1'b1;
            end
         end
         CMD_WR_ENABLES: begin
            enables_in = write_data[6:3];
            evaluate   = 1'b1;
         end
         CMD_WR_COMPARE: begin
            compare_in = write_data;
         end
         CMD_RECHECK: begin
            evaluate = 1'b1;
         end
         default: begin
            // unused commands: plain readback
         end
      endcase
   end

   // Status line level on the updated state; edge against the stored level.
   always_comb begin
      level = (enables_in[EN_COMPARE_BIT] && (line_in == compare_in))
           || (enables_in[EN_HBLANK_BIT] && (mode_in == MODE_HBLANK))
           || (enables_in[EN_VBLANK_BIT] && (mode_in == MODE_VBLANK))
           || (enables_in[EN_SEARCH_BIT] && (mode_in == MODE_SEARCH));
      stat_pulse  = evaluate && level && !prev_irq_ff;
      prev_irq_in = evaluate ? level : prev_irq_ff;
   end

   always_comb begin
      status_read = {1'b1, enables_in, (line_in == compare_in),
                     control_in[DISPLAY_ON_BIT] ? mode_in : 2'd0};
      out_data_in = {3'd0, render, vblank_pulse, stat_pulse, mode_in, line_in,
                     status_read};
      // Hold a stalled result; drop it once taken with nothing new behind it.
      if (req_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= CONTROL_RESET;
         enables_ff   <= 4'd0;
         compare_ff   <= 8'd0;
         line_ff      <= 8'd0;
         mode_ff      <= MODE_SEARCH;
         count_ff     <= 10'd0;
         prev_irq_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_fire) begin
            control_ff  <= control_in;
            enables_ff  <= enables_in;
            compare_ff  <= compare_in;
            line_ff     <= line_in;
            mode_ff     <= mode_in;
            count_ff    <= count_in;
            prev_irq_ff <= prev_irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // A vblank pulse always reports vblank mode.
   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[19]) |-> (rsp_tdata[17:16] == MODE_VBLANK))
      else $error("vblank pulse outside vblank mode");

   // A line render is flagged only on the move into hblank.
   a_render_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20]) |-> (rsp_tdata[17:16] == MODE_HBLANK))
      else $error("render flag outside hblank");

   // A status edge leaves the stored level high.
   a_stat_level: assert property (@(posedge clock) disable iff (reset)
      (req_fire && stat_pulse) |=> prev_irq_ff)
      else $error("status edge without stored level");

   // A result that was not taken stays put.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("pending result changed");

endmodule
